### hw/rtl/hdwt_pkg.sv
package hdwt_pkg;

  localparam int MAX_SIDE_DEF    = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int CFG_W      = 7;
  localparam int COORD_W    = 6;
  localparam int SIDE_LIMIT = 2 ** CFG_W - 2;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(64);

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [1:0] BAND_LL = 2'd0;
  localparam logic [1:0] BAND_HL = 2'd1;
  localparam logic [1:0] BAND_LH = 2'd2;
  localparam logic [1:0] BAND_HH = 2'd3;

  typedef struct packed {
    logic [COORD_W-1:0] row_top;
    logic [COORD_W-1:0] row_bot;
    logic [COORD_W-1:0] col_left;
    logic [COORD_W-1:0] col_right;
    logic               last;
  } quad_meta_t;

endpackage

### hw/rtl/hdwt_quad_emit.sv
module hdwt_quad_emit
  import hdwt_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    quad_valid,
  output logic                    quad_ready,
  input  quad_meta_t              quad_meta,
  input  logic signed [SAMPLE_BITS:0] sum_ab,
  input  logic signed [SAMPLE_BITS:0] dif_ab,
  input  logic signed [SAMPLE_BITS:0] sum_cd,
  input  logic signed [SAMPLE_BITS:0] dif_cd,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  // coefficient_x2, out_row, out_col, zero fill
  output logic [((SAMPLE_BITS + 2 + 2 * COORD_W + 7) / 8) * 8 - 1:0] m_tdata,
  // subband
  output logic [1:0]              m_tuser,
  output logic                    m_tlast
);

  localparam int COEF_W = SAMPLE_BITS + 2;
  localparam int DATA_W = ((COEF_W + 2 * COORD_W + 7) / 8) * 8;

  logic                       qvalid;
  quad_meta_t                 qmeta;
  logic signed [SAMPLE_BITS:0] q_sum_ab;
  logic signed [SAMPLE_BITS:0] q_dif_ab;
  logic signed [SAMPLE_BITS:0] q_sum_cd;
  logic signed [SAMPLE_BITS:0] q_dif_cd;
  logic [1:0]                 band;
  logic                       load;
  logic                       quad_done;
  logic signed [COEF_W-1:0]   coef;
  logic [COORD_W-1:0]         row_sel;
  logic [COORD_W-1:0]         col_sel;

  assign load       = qvalid && (!m_tvalid || m_tready);
  assign quad_done  = load && (band == BAND_HH);
  assign quad_ready = !qvalid || quad_done;

  always_comb begin
    unique case (band)
      BAND_LL: begin
        coef = COEF_W'(q_sum_ab) + COEF_W'(q_sum_cd);
        row_sel = qmeta.row_top;
        col_sel = qmeta.col_left;
      end
      BAND_HL: begin
        coef = COEF_W'(q_dif_ab) + COEF_W'(q_dif_cd);
        row_sel = qmeta.row_top;
        col_sel = qmeta.col_right;
      end
      BAND_LH: begin
        coef = COEF_W'(q_sum_ab) - COEF_W'(q_sum_cd);
        row_sel = qmeta.row_bot;
        col_sel = qmeta.col_left;
      end
      default: begin
        coef = COEF_W'(q_dif_ab) - COEF_W'(q_dif_cd);
        row_sel = qmeta.row_bot;
        col_sel = qmeta.col_right;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qvalid   <= 1'b0;
      band     <= BAND_LL;
      m_tvalid <= 1'b0;
    end else begin
      if (quad_valid && quad_ready) begin
        qvalid <= 1'b1;
      end else if (quad_done) begin
        qvalid <= 1'b0;
      end
      if (load) begin
        band     <= band + 2'd1;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (quad_valid && quad_ready) begin
      qmeta    <= quad_meta;
      q_sum_ab <= sum_ab;
      q_dif_ab <= dif_ab;
      q_sum_cd <= sum_cd;
      q_dif_cd <= dif_cd;
    end
    if (load) begin
      m_tdata <= DATA_W'({col_sel, row_sel, coef});
      m_tuser <= band;
      m_tlast <= qmeta.last && (band == BAND_HH);
    end
  end

endmodule

### hw/rtl/haar_dwt_2d_one_level.sv
// One-level 2D Haar transform of one channel of a block, one sample per beat.
// Input stream (s_*): samples in raster order; tdata holds the signed sample.
// Output stream (m_*): four coefficient beats per 2x2 quad in the order LL, HL,
// LH, HH; tdata holds coefficient_x2, out_row, out_col, tuser the subband and
// tlast marks the HH beat of the final quad of the block.
// APB port: width register at 0x0, height register at 0x4, bit zero ignored; a
// write restarts the block at row 0, column 0. Writes only while the block is idle.
// Throughput: even-row samples and even-column samples are taken one per
// cycle; a quad holds the emitter for its four beats, so the sample that
// completes the next quad waits until the HH beat of the previous quad is loaded.
// The quad's sums are registered in the emitter and its LL beat is then loaded
// into the output register. The even row is kept as column pairs in a small
// memory read one sample ahead of the quad.
// Reset: sizes return to 64, position to row 0, column 0, both streams empty.
// A stalled output holds its beat; one completed quad waits behind it while
// samples that complete no quad keep being taken.
module haar_dwt_2d_one_level
  import hdwt_pkg::*;
#(
  parameter int MAX_SIDE    = MAX_SIDE_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // sample, zero fill
  input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // coefficient_x2, out_row, out_col, zero fill
  output logic [((SAMPLE_BITS + 2 + 2 * COORD_W + 7) / 8) * 8 - 1:0] m_tdata,
  // subband
  output logic [1:0]               m_tuser,
  output logic                     m_tlast,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_AW-1:0]        paddr,
  input  logic [APB_DW-1:0]        pwdata,
  output logic [APB_DW-1:0]        prdata,
  output logic                     pready
);

  localparam int SIDE_CAP   = (MAX_SIDE >= SIDE_LIMIT) ? SIDE_LIMIT : (MAX_SIDE & ~1);
  localparam int SIDE_W     = $clog2(SIDE_CAP + 1);
  localparam int POS_W      = (SIDE_CAP > 2) ? $clog2(SIDE_CAP) : 1;
  localparam int PAIR_DEPTH = SIDE_CAP / 2;
  localparam int PAIR_AW    = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;

  logic [CFG_W-1:0]  width_cfg;
  logic [CFG_W-1:0]  height_cfg;
  logic [CFG_W-1:0]  w_clip;
  logic [CFG_W-1:0]  h_clip;
  logic [SIDE_W-1:0] eff_w;
  logic [SIDE_W-1:0] eff_h;
  logic              cfg_wr;

  logic [POS_W-1:0]  row_pos;
  logic [POS_W-1:0]  col_pos;
  logic [POS_W-1:0]  row_cur;
  logic [POS_W-1:0]  col_cur;
  logic [POS_W-1:0]  row_pos_next;
  logic [POS_W-1:0]  col_pos_next;
  logic [SIDE_W-1:0] col_inc;
  logic [SIDE_W-1:0] row_inc;

  logic [2*SAMPLE_BITS-1:0] pair_mem [PAIR_DEPTH];
  logic [2*SAMPLE_BITS-1:0] pair_rd;
  logic [PAIR_AW-1:0]       pair_idx;
  logic [SAMPLE_BITS-1:0]   hold;

  logic signed [SAMPLE_BITS-1:0] smp;
  logic signed [SAMPLE_BITS-1:0] qa;
  logic signed [SAMPLE_BITS-1:0] qb;
  logic signed [SAMPLE_BITS-1:0] qc;
  logic              s_accept;
  logic              quad_pos;
  logic              quad_ready;
  quad_meta_t        quad_meta;
  logic signed [SAMPLE_BITS:0] sum_ab;
  logic signed [SAMPLE_BITS:0] dif_ab;
  logic signed [SAMPLE_BITS:0] sum_cd;
  logic signed [SAMPLE_BITS:0] dif_cd;

  // apb registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_cfg  <= SIZE_RESET;
      height_cfg <= SIZE_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_WIDTH: width_cfg  <= pwdata[CFG_W-1:0];
        default:   height_cfg <= pwdata[CFG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WIDTH: prdata = APB_DW'(width_cfg);
      default:   prdata = APB_DW'(height_cfg);
    endcase
  end

  // even sizes clamped to 2 .. cap
  always_comb begin
    w_clip = {width_cfg[CFG_W-1:1], 1'b0};
    h_clip = {height_cfg[CFG_W-1:1], 1'b0};
    if (w_clip < CFG_W'(2)) begin
      w_clip = CFG_W'(2);
    end else if (w_clip > CFG_W'(SIDE_CAP)) begin
      w_clip = CFG_W'(SIDE_CAP);
    end
    if (h_clip < CFG_W'(2)) begin
      h_clip = CFG_W'(2);
    end else if (h_clip > CFG_W'(SIDE_CAP)) begin
      h_clip = CFG_W'(SIDE_CAP);
    end
  end

  assign eff_w = SIDE_W'(w_clip);
  assign eff_h = SIDE_W'(h_clip);

  // raster position
  always_comb begin
    row_cur = row_pos;
    col_cur = col_pos;
    if (SIDE_W'(row_pos) >= eff_h || SIDE_W'(col_pos) >= eff_w) begin
      row_cur = '0;
      col_cur = '0;
    end
    col_inc = SIDE_W'(col_cur) + SIDE_W'(1);
    row_inc = SIDE_W'(row_cur) + SIDE_W'(1);
    row_pos_next = row_cur;
    col_pos_next = POS_W'(col_inc);
    if (col_inc >= eff_w) begin
      col_pos_next = '0;
      row_pos_next = (row_inc >= eff_h) ? '0 : POS_W'(row_inc);
    end
  end

  assign smp      = SAMPLE_BITS'(s_tdata);
  assign quad_pos = row_cur[0] && col_cur[0];
  assign s_tready = !quad_pos || quad_ready;
  assign s_accept = s_tvalid && s_tready;
  assign pair_idx = PAIR_AW'(col_cur >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (cfg_wr) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (s_accept) begin
      row_pos <= row_pos_next;
      col_pos <= col_pos_next;
    end
  end

  // even row kept as column pairs, fetched at the even column of the odd row
  always_ff @(posedge clk) begin
    if (s_accept) begin
      if (!col_cur[0]) begin
        hold <= smp;
      end
      if (!row_cur[0] && col_cur[0]) begin
        pair_mem[pair_idx] <= {smp, hold};
      end
      if (row_cur[0] && !col_cur[0]) begin
        pair_rd <= pair_mem[pair_idx];
      end
    end
  end

  assign qa = pair_rd[SAMPLE_BITS-1:0];
  assign qb = pair_rd[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign qc = hold;

  assign sum_ab = (SAMPLE_BITS + 1)'(qa) + (SAMPLE_BITS + 1)'(qb);
  assign dif_ab = (SAMPLE_BITS + 1)'(qa) - (SAMPLE_BITS + 1)'(qb);
  assign sum_cd = (SAMPLE_BITS + 1)'(qc) + (SAMPLE_BITS + 1)'(smp);
  assign dif_cd = (SAMPLE_BITS + 1)'(qc) - (SAMPLE_BITS + 1)'(smp);

  always_comb begin
    quad_meta.row_top   = COORD_W'(row_cur >> 1);
    quad_meta.row_bot   = COORD_W'(SIDE_W'(row_cur >> 1) + (eff_h >> 1));
    quad_meta.col_left  = COORD_W'(col_cur >> 1);
    quad_meta.col_right = COORD_W'(SIDE_W'(col_cur >> 1) + (eff_w >> 1));
    quad_meta.last      = (SIDE_W'(row_cur) == eff_h - SIDE_W'(1)) &&
                          (SIDE_W'(col_cur) == eff_w - SIDE_W'(1));
  end

  hdwt_quad_emit #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_emit (
    .clk        (clk),
    .rst        (rst),
    .quad_valid (s_tvalid && quad_pos),
    .quad_ready (quad_ready),
    .quad_meta  (quad_meta),
    .sum_ab     (sum_ab),
    .dif_ab     (dif_ab),
    .sum_cd     (sum_cd),
    .dif_cd     (dif_cd),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> (row_pos == '0 && col_pos == '0))
    else $error("position not cleared after register write");

  a_pos_in_block: assert property (@(posedge clk) disable iff (rst)
    (SIDE_W'(row_pos) < eff_h && SIDE_W'(col_pos) < eff_w))
    else $error("raster position outside the block");

  a_last_on_hh: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tuser == BAND_HH))
    else $error("end of block marked on a beat other than hh");

endmodule
